// File: rtl/core/sdes_ctr_pkg.sv
package sdes_ctr_pkg;

  // Configuration register indexes.
  localparam logic CfgCipherKey    = 1'b0;
  localparam logic CfgStartCounter = 1'b1;

  localparam int unsigned KeyW  = 10;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgW  = 10;

  // One byte on its way from the front end to the keystream stage.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] counter;
  } mid_item_t;

  // Permutation tables: output bit i (1 = MSB) takes input bit tab[i] (1 = MSB).
  localparam int unsigned P10Tab[10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
  localparam int unsigned P8Tab[8]   = '{6, 3, 7, 4, 8, 5, 10, 9};
  localparam int unsigned IpTab[8]   = '{2, 6, 3, 1, 4, 8, 5, 7};
  localparam int unsigned IpiTab[8]  = '{4, 1, 3, 5, 7, 2, 8, 6};
  localparam int unsigned EpTab[8]   = '{4, 1, 2, 3, 2, 3, 4, 1};
  localparam int unsigned P4Tab[4]   = '{2, 4, 3, 1};

  // Substitution boxes, indexed by row and then column.
  localparam logic [1:0] Sbox0[4][4] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd3, 2'd1, 2'd3, 2'd2}
  };
  localparam logic [1:0] Sbox1[4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3}
  };

  function automatic logic [9:0] perm_p10(input logic [9:0] v);
    logic [9:0] r;
    r = '0;
    for (int i = 0; i < 10; i++) begin
      r[9-i] = v[10-P10Tab[i]];
    end
    return r;
  endfunction

  function automatic logic [7:0] perm_p8(input logic [9:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[10-P8Tab[i]];
    end
    return r;
  endfunction

  function automatic logic [7:0] perm_ip(input logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[8-IpTab[i]];
    end
    return r;
  endfunction

  function automatic logic [7:0] perm_ipi(input logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[8-IpiTab[i]];
    end
    return r;
  endfunction

  function automatic logic [7:0] perm_ep(input logic [3:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[4-EpTab[i]];
    end
    return r;
  endfunction

  function automatic logic [3:0] perm_p4(input logic [3:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[3-i] = v[4-P4Tab[i]];
    end
    return r;
  endfunction

  // Feistel round function: expand, mix in the subkey, substitute, permute.
  function automatic logic [3:0] fround(input logic [3:0] half, input logic [7:0] sk);
    logic [7:0] x;
    logic [1:0] r0, c0, r1, c1;
    x  = perm_ep(half) ^ sk;
    r0 = {x[7], x[4]};
    c0 = x[6:5];
    r1 = {x[3], x[0]};
    c1 = x[2:1];
    return perm_p4({Sbox0[r0][c0], Sbox1[r1][c1]});
  endfunction

  // S-DES encryption of one block; both subkeys come straight from the key.
  function automatic logic [7:0] sdes_encrypt(input logic [7:0] blk,
                                              input logic [KeyW-1:0] key);
    logic [9:0] k10;
    logic [4:0] lh1, rh1, lh3, rh3;
    logic [7:0] k1, k2, ip;
    logic [3:0] l1, l2;
    k10 = perm_p10(key);
    lh1 = {k10[8:5], k10[9]};
    rh1 = {k10[3:0], k10[4]};
    lh3 = {lh1[2:0], lh1[4:3]};
    rh3 = {rh1[2:0], rh1[4:3]};
    k1  = perm_p8({lh1, rh1});
    k2  = perm_p8({lh3, rh3});
    ip  = perm_ip(blk);
    l1  = ip[7:4] ^ fround(ip[3:0], k1);
    l2  = ip[3:0] ^ fround(l1, k2);
    return perm_ipi({l2, l1});
  endfunction

endpackage

// File: rtl/core/sdes_ctr_fifo.sv
module sdes_ctr_fifo #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/sdes_ctr_front.sv
module sdes_ctr_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    restart_i,
  output logic                    full_o,
  input  logic [7:0]              start_counter_i,
  output logic                    mid_push_o,
  output sdes_ctr_pkg::mid_item_t mid_item_o,
  input  logic                    mid_full_i
);

  logic [7:0] counter_q, counter_d, counter_used;
  logic       accept;

  assign full_o       = mid_full_i;
  assign accept       = push_i & ~mid_full_i;
  assign mid_push_o   = accept;

  // A restart reloads the counter before this byte uses it.
  assign counter_used = restart_i ? start_counter_i : counter_q;
  assign counter_d    = accept ? counter_used + 8'd1 : counter_q;

  assign mid_item_o.data_byte = data_byte_i;
  assign mid_item_o.counter   = counter_used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
    end else begin
      counter_q <= counter_d;
    end
  end

endmodule

// File: rtl/core/sdes_ctr_back.sv
module sdes_ctr_back (
  input  logic                            mid_empty_i,
  input  sdes_ctr_pkg::mid_item_t         mid_item_i,
  output logic                            mid_pop_o,
  input  logic [sdes_ctr_pkg::KeyW-1:0]   cipher_key_i,
  output logic                            out_push_o,
  output logic [7:0]                      out_byte_o,
  input  logic                            out_full_i
);

  logic [7:0] keystream;

  // Move one byte whenever there is one waiting and room behind.
  assign mid_pop_o  = ~mid_empty_i & ~out_full_i;
  assign out_push_o = mid_pop_o;

  // Keystream is the S-DES encryption of the counter.
  assign keystream  = sdes_ctr_pkg::sdes_encrypt(mid_item_i.counter, cipher_key_i);
  assign out_byte_o = mid_item_i.data_byte ^ keystream;

endmodule

// File: rtl/core/sdes_counter_mode_cipher_core.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------
// input     | push / full        | data_byte_i[7:0], restart_i
// result    | pop / empty        | out_byte_o[7:0]
// config    | cfg_we_i           | cfg_idx_i, cfg_wdata_i[9:0]
//
// One byte per cycle when nothing stalls; each byte is registered in both
// queues. The front end owns the counter; the keystream stage encrypts it.
// Reset clears the key, the start value, the counter and both queues.
// Either side may stall: the queues between the stages absorb back pressure.
module sdes_counter_mode_cipher_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        data_byte_i,
  input  logic                              restart_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [7:0]                        out_byte_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [sdes_ctr_pkg::CfgW-1:0]     cfg_wdata_i
);

  localparam int unsigned MidW = $bits(sdes_ctr_pkg::mid_item_t);

  logic [sdes_ctr_pkg::KeyW-1:0] cipher_key_q, cipher_key_d;
  logic [7:0]                    start_counter_q, start_counter_d;

  logic                    mid_push, mid_full, mid_pop, mid_empty;
  sdes_ctr_pkg::mid_item_t mid_in, mid_out;
  logic [MidW-1:0]         mid_out_bits;
  logic                    out_push, out_full;
  logic [7:0]              out_byte_new;

  // Configuration register decode.
  always_comb begin
    cipher_key_d    = cipher_key_q;
    start_counter_d = start_counter_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdes_ctr_pkg::CfgCipherKey:    cipher_key_d    = cfg_wdata_i[sdes_ctr_pkg::KeyW-1:0];
        sdes_ctr_pkg::CfgStartCounter: start_counter_d = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q    <= '0;
      start_counter_q <= '0;
    end else begin
      cipher_key_q    <= cipher_key_d;
      start_counter_q <= start_counter_d;
    end
  end

  // Front end: accepts bytes and assigns counter values.
  sdes_ctr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .data_byte_i     (data_byte_i),
    .restart_i       (restart_i),
    .full_o          (full),
    .start_counter_i (start_counter_q),
    .mid_push_o      (mid_push),
    .mid_item_o      (mid_in),
    .mid_full_i      (mid_full)
  );

  // Queue between front end and keystream stage.
  sdes_ctr_fifo #(
    .Width (MidW),
    .Depth (QueueDepth)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out_bits),
    .empty_o (mid_empty)
  );

  assign mid_out = sdes_ctr_pkg::mid_item_t'(mid_out_bits);

  // Keystream stage.
  sdes_ctr_back u_back (
    .mid_empty_i  (mid_empty),
    .mid_item_i   (mid_out),
    .mid_pop_o    (mid_pop),
    .cipher_key_i (cipher_key_q),
    .out_push_o   (out_push),
    .out_byte_o   (out_byte_new),
    .out_full_i   (out_full)
  );

  // Result queue facing the consumer.
  sdes_ctr_fifo #(
    .Width (8),
    .Depth (QueueDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_byte_new),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_byte_o),
    .empty_o (empty)
  );

endmodule

// File: verif/tb_sdes_counter_mode_cipher_core.sv
`timescale 1ns / 1ps

module tb_sdes_counter_mode_cipher_core;

  localparam int unsigned CfgW        = sdes_ctr_pkg::CfgW;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned NumPhases   = 10;
  localparam int unsigned PhaseBytes  = 145;

  // Bit selections: entry i names the source bit (1 = MSB) for output bit i (1 = MSB).
  typedef int unsigned pos_list_t [10];

  localparam pos_list_t SelP10 = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
  localparam pos_list_t SelP8  = '{6, 3, 7, 4, 8, 5, 10, 9, 0, 0};
  localparam pos_list_t SelIp  = '{2, 6, 3, 1, 4, 8, 5, 7, 0, 0};
  localparam pos_list_t SelIpi = '{4, 1, 3, 5, 7, 2, 8, 6, 0, 0};
  localparam pos_list_t SelEp  = '{4, 1, 2, 3, 2, 3, 4, 1, 0, 0};
  localparam pos_list_t SelP4  = '{2, 4, 3, 1, 0, 0, 0, 0, 0, 0};

  localparam logic [1:0] BoxLeft [4][4] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd3, 2'd1, 2'd3, 2'd2}
  };
  localparam logic [1:0] BoxRight [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3}
  };

  // Directed stimulus: a byte transfer or a register write per row.
  typedef enum logic {RowByte, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             reg_idx;
    logic [CfgW-1:0]  reg_val;
    logic [7:0]       data;
    logic             rs;
    logic             chk;
    logic [7:0]       want;
  } dir_row_t;

  // Known values: after reset the key and counter are zero, and the S-DES
  // block of zero under the zero key is F0.
  localparam dir_row_t DirTab [26] = '{
    '{RowByte, 1'b0, 10'h000, 8'h00, 1'b0, 1'b1, 8'hF0},
    '{RowByte, 1'b0, 10'h000, 8'hFF, 1'b1, 1'b1, 8'h0F},
    '{RowByte, 1'b0, 10'h000, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h55, 1'b0, 1'b0, 8'h00},
    '{RowReg,  sdes_ctr_pkg::CfgStartCounter, 10'h0FE, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h00, 1'b1, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'hAA, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h00, 1'b0, 1'b1, 8'hF0},
    '{RowReg,  sdes_ctr_pkg::CfgCipherKey, 10'h3FF, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'hFF, 1'b1, 1'b0, 8'h00},
    '{RowReg,  sdes_ctr_pkg::CfgCipherKey, 10'h282, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowReg,  sdes_ctr_pkg::CfgStartCounter, 10'h000, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h00, 1'b1, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h80, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h01, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h7F, 1'b0, 1'b0, 8'h00},
    '{RowReg,  sdes_ctr_pkg::CfgCipherKey, 10'h155, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowReg,  sdes_ctr_pkg::CfgStartCounter, 10'h0FF, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h5A, 1'b1, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'hA5, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h3C, 1'b1, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'hC3, 1'b0, 1'b0, 8'h00},
    '{RowReg,  sdes_ctr_pkg::CfgCipherKey, 10'h2AA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'h00, 1'b0, 1'b0, 8'h00},
    '{RowByte, 1'b0, 10'h000, 8'hFF, 1'b0, 1'b0, 8'h00}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            push;
  logic            full;
  logic [7:0]      data_byte;
  logic            restart;
  logic            empty;
  logic            pop;
  logic [7:0]      out_byte;
  logic            cfg_we;
  logic            cfg_idx;
  logic [CfgW-1:0] cfg_wdata;

  // Known result for a directed row, sent along with the byte.
  logic            chk_en;
  logic [7:0]      chk_val;

  // Predictor copy of the registers and the counter.
  logic [9:0]      key_reg   = '0;
  logic [7:0]      start_reg = '0;
  logic [7:0]      ctr_value = '0;

  logic [7:0]      pending_out_bytes [$];
  int unsigned     error_cnt = 0;
  int unsigned     cycle_cnt = 0;
  bit              steady    = 1'b0;

  sdes_counter_mode_cipher_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte),
    .restart_i   (restart),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [9:0] select_bits(input logic [9:0] src, input int unsigned src_w,
                                             input pos_list_t sel, input int unsigned n);
    logic [9:0] dst;
    dst = '0;
    for (int i = 0; i < n; i++) begin
      dst[n-1-i] = src[src_w-sel[i]];
    end
    return dst;
  endfunction

  function automatic logic [4:0] rotl5(input logic [4:0] h, input int unsigned k);
    logic [9:0] twice;
    twice = {h, h};
    return twice[9-k -: 5];
  endfunction

  // One Feistel round: expand, add the subkey, look up both boxes, permute.
  function automatic logic [3:0] round_mix(input logic [3:0] half, input logic [7:0] sk);
    logic [7:0] x;
    logic [3:0] s;
    x = 8'(select_bits({6'b0, half}, 4, SelEp, 8)) ^ sk;
    s = {BoxLeft[{x[7], x[4]}][x[6:5]], BoxRight[{x[3], x[0]}][x[2:1]]};
    return 4'(select_bits({6'b0, s}, 4, SelP4, 4));
  endfunction

  // S-DES encryption of the counter block under the given key.
  function automatic logic [7:0] keystream_byte(input logic [7:0] blk, input logic [9:0] key);
    logic [9:0] k10;
    logic [4:0] lh, rh;
    logic [7:0] k1, k2, ip;
    logic [3:0] l1, l2;
    k10 = select_bits(key, 10, SelP10, 10);
    lh  = rotl5(k10[9:5], 1);
    rh  = rotl5(k10[4:0], 1);
    k1  = 8'(select_bits({lh, rh}, 10, SelP8, 8));
    lh  = rotl5(lh, 2);
    rh  = rotl5(rh, 2);
    k2  = 8'(select_bits({lh, rh}, 10, SelP8, 8));
    ip  = 8'(select_bits({2'b0, blk}, 8, SelIp, 8));
    l1  = ip[7:4] ^ round_mix(ip[3:0], k1);
    l2  = ip[3:0] ^ round_mix(l1, k2);
    return 8'(select_bits({2'b0, l2, l1}, 8, SelIpi, 8));
  endfunction

  // Track register writes, predict each accepted byte and check each result transfer.
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni) begin
      if (cfg_we) begin
        if (cfg_idx == sdes_ctr_pkg::CfgCipherKey) begin
          key_reg = cfg_wdata[9:0];
        end else if (cfg_idx == sdes_ctr_pkg::CfgStartCounter) begin
          start_reg = cfg_wdata[7:0];
        end
      end
      if (push && !full) begin
        if (restart) begin
          ctr_value = start_reg;
        end
        want = data_byte ^ keystream_byte(ctr_value, key_reg);
        ctr_value = ctr_value + 8'd1;
        pending_out_bytes.push_back(chk_en ? chk_val : want);
      end
      if (pop && !empty) begin
        if (pending_out_bytes.size() == 0) begin
          $display("%0t: result %02h arrived with nothing expected", $time, out_byte);
          error_cnt++;
        end else begin
          want = pending_out_bytes.pop_front();
          if (out_byte !== want) begin
            $display("%0t: out_byte expected %02h, actual %02h", $time, want, out_byte);
            error_cnt++;
          end
        end
      end
    end
  end

  // The result side stalls at random except during the steady stretch.
  always @(negedge clk_i) begin
    pop <= steady || ($urandom_range(99) >= 16);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Register writes happen only once every expected byte has come back.
  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    push <= 1'b0;
    while (pending_out_bytes.size() != 0) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
  endtask

  // Offer one byte after a random gap (none in the steady stretch) and hold it until the transfer.
  task automatic send_byte(input logic [7:0] d, input logic rs,
                           input logic chk, input logic [7:0] want);
    cfg_we <= 1'b0;
    while (!steady && $urandom_range(99) < 16) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    data_byte <= d;
    restart   <= rs;
    chk_en    <= chk;
    chk_val   <= want;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned ph;
    int unsigned k;
    logic [9:0]  key_val;
    logic [7:0]  start_val;

    rst_ni    = 1'b0;
    push      = 1'b0;
    data_byte = '0;
    restart   = 1'b0;
    pop       = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = sdes_ctr_pkg::CfgCipherKey;
    cfg_wdata = '0;
    chk_en    = 1'b0;
    chk_val   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows: reset values, counter wrap, key and start extremes.
    foreach (DirTab[i]) begin
      if (DirTab[i].kind == RowReg) begin
        write_reg(DirTab[i].reg_idx, DirTab[i].reg_val);
      end else begin
        send_byte(DirTab[i].data, DirTab[i].rs, DirTab[i].chk, DirTab[i].want);
      end
    end

    // Random streams, each writing a key and start value: fixed extremes first, then random ones.
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          key_val   = 10'h000;
          start_val = 8'hFF;
        end
        1: begin
          key_val   = 10'h3FF;
          start_val = 8'h00;
        end
        2: begin
          key_val   = 10'h3FF;
          start_val = 8'hFF;
        end
        default: begin
          key_val   = 10'($urandom_range(1023));
          start_val = 8'($urandom_range(255));
        end
      endcase
      write_reg(sdes_ctr_pkg::CfgCipherKey, key_val);
      write_reg(sdes_ctr_pkg::CfgStartCounter, {2'($urandom_range(3)), start_val});
      steady = (ph == 2);
      for (k = 0; k < PhaseBytes; k++) begin
        send_byte(8'($urandom_range(255)), (k == 0) || ($urandom_range(11) == 0),
                  1'b0, 8'h00);
      end
    end
    steady = 1'b0;
    push <= 1'b0;

    // Drain, then give a late result the chance to show up.
    while (pending_out_bytes.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (pending_out_bytes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_out_bytes.size());
      error_cnt++;
    end
    if (error_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sdes_ctr_pkg.sv
rtl/core/sdes_ctr_fifo.sv
rtl/core/sdes_ctr_front.sv
rtl/core/sdes_ctr_back.sv
rtl/core/sdes_counter_mode_cipher_core.sv
verif/tb_sdes_counter_mode_cipher_core.sv
